[src/array_min_priority_queue_macros.svh]
// Assertion macros used by the checker file of the priority queue.
`ifndef ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, clocked on aclk and disabled during reset.
`define AMPQ_ASSERT_IMM(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, clocked on aclk and disabled during reset.
`define AMPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[src/ampq_pkg.sv]
// Shared constants and codes of the array-based minimum priority queue.
package ampq_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int HANDLE_BITS_DEFAULT = 32;

    localparam int HANDLE_PORT_BITS   = 32;
    localparam int PRIORITY_BITS      = 64;
    localparam int CAP_BITS           = 5;
    localparam int COUNT_PORT_BITS    = 5;
    localparam int POSITION_PORT_BITS = 4;
    localparam int STATUS_BITS        = 2;

    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

    typedef logic [STATUS_BITS-1:0] status_t;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

endpackage

[src/ampq_ram.sv]
// Simple dual-port entry memory with one write port and one registered read port.
module ampq_ram #(
    parameter int DEPTH     = 16,
    parameter int DATA_BITS = 96
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]     rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[src/array_min_priority_queue.sv]
// Minimum priority queue kept as an unsorted array of handle and priority entries.
// One request is taken at a time. An insert, a refused insert and a pop on an empty
// queue go straight to the finish state, and the next request is taken once the result
// is loaded into the output register. A pop on a queue holding N entries sweeps all N
// entries through the single read port of the entry memory, one per cycle, compacting
// the array behind the removed entry and rescanning for the new minimum in the same
// pass. A result waits in the output register until it is taken; the next result is not loaded before then.
module array_min_priority_queue #(
    parameter int DEPTH       = ampq_pkg::DEPTH_DEFAULT,
    parameter int HANDLE_BITS = ampq_pkg::HANDLE_BITS_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ampq_pkg::CAP_BITS-1:0]           cfg_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_cmd,
    input  logic [ampq_pkg::HANDLE_PORT_BITS-1:0]   s_handle,
    input  logic [ampq_pkg::PRIORITY_BITS-1:0]      s_priority_req,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output ampq_pkg::status_t                       m_status,
    output logic [ampq_pkg::HANDLE_PORT_BITS-1:0]   m_handle_out,
    output logic [ampq_pkg::COUNT_PORT_BITS-1:0]    m_count,
    output logic [ampq_pkg::POSITION_PORT_BITS-1:0] m_min_position
);

    import ampq_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CAPW = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam int HW   = (HANDLE_BITS < HANDLE_PORT_BITS) ? HANDLE_BITS : HANDLE_PORT_BITS;
    localparam int DW   = HW + PRIORITY_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [PRIORITY_BITS-1:0] min_value_reg, min_value_next;
    logic [IW-1:0]            min_index_reg, min_index_next;
    logic [CAP_BITS-1:0]      capacity_reg, capacity_next;
    logic [CW-1:0]            issue_reg, issue_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [IW-1:0]            pend_idx_reg, pend_idx_next;
    logic [PRIORITY_BITS-1:0] scan_min_reg, scan_min_next;
    logic [IW-1:0]            scan_idx_reg, scan_idx_next;
    logic                     scan_first_reg, scan_first_next;
    status_t                  res_status_reg, res_status_next;
    logic [HW-1:0]            res_handle_reg, res_handle_next;
    logic                     m_valid_reg, m_valid_next;
    status_t                  m_status_reg, m_status_next;
    logic [HANDLE_PORT_BITS-1:0]   m_handle_reg, m_handle_next;
    logic [COUNT_PORT_BITS-1:0]    m_count_reg, m_count_next;
    logic [POSITION_PORT_BITS-1:0] m_minpos_reg, m_minpos_next;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic [DW-1:0]            wr_data;
    logic [IW-1:0]            rd_addr;
    logic [DW-1:0]            rd_data;
    logic [HW-1:0]            rd_handle;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [CAPW-1:0]          eff_cap;
    logic                     full;
    logic [IW-1:0]            new_pos;

    ampq_ram #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_handle = rd_data[PRIORITY_BITS +: HW];
    assign rd_prio   = rd_data[PRIORITY_BITS-1:0];
    assign rd_addr   = issue_reg[IW-1:0];

    assign eff_cap = (CAPW'(capacity_reg) > CAPW'(DEPTH)) ? CAPW'(DEPTH)
                                                           : CAPW'(capacity_reg);
    assign full    = CAPW'(count_reg) >= eff_cap;
    assign new_pos = (pend_idx_reg < min_index_reg) ? pend_idx_reg : pend_idx_reg - IW'(1);

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_handle_out   = m_handle_reg;
    assign m_count        = m_count_reg;
    assign m_min_position = m_minpos_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        min_value_next  = min_value_reg;
        min_index_next  = min_index_reg;
        capacity_next   = capacity_reg;
        issue_next      = issue_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        scan_min_next   = scan_min_reg;
        scan_idx_next   = scan_idx_reg;
        scan_first_next = scan_first_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_handle_next   = m_handle_reg;
        m_count_next    = m_count_reg;
        m_minpos_next   = m_minpos_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IW-1:0];
        wr_data         = {s_handle[HW-1:0], s_priority_req};

        if (cfg_valid) begin
            capacity_next = cfg_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_handle_next = '0;
                    state_next      = ST_FINISH;
                    if (s_cmd == CMD_INSERT) begin
                        if (full) begin
                            res_status_next = STATUS_FULL;
                        end else begin
                            res_status_next = STATUS_DONE;
                            wr_en           = 1'b1;
                            count_next      = count_reg + CW'(1);
                            if (count_reg == '0 || s_priority_req < min_value_reg) begin
                                min_value_next = s_priority_req;
                                min_index_next = count_reg[IW-1:0];
                            end
                        end
                    end else if (count_reg == '0 || CW'(min_index_reg) >= count_reg) begin
                        res_status_next = STATUS_EMPTY;
                    end else begin
                        res_status_next = STATUS_DONE;
                        issue_next      = '0;
                        pend_valid_next = 1'b0;
                        scan_min_next   = '1;
                        scan_idx_next   = '0;
                        scan_first_next = 1'b1;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg < count_reg) begin
                    issue_next      = issue_reg + CW'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg[IW-1:0];
                end else begin
                    pend_valid_next = 1'b0;
                end
                if (pend_valid_reg) begin
                    if (pend_idx_reg == min_index_reg) begin
                        res_handle_next = rd_handle;
                    end else begin
                        if (scan_first_reg || rd_prio < scan_min_reg) begin
                            scan_min_next   = rd_prio;
                            scan_idx_next   = new_pos;
                            scan_first_next = 1'b0;
                        end
                        if (pend_idx_reg > min_index_reg) begin
                            wr_en   = 1'b1;
                            wr_addr = new_pos;
                            wr_data = rd_data;
                        end
                    end
                end else if (issue_reg == count_reg) begin
                    count_next     = count_reg - CW'(1);
                    min_value_next = scan_min_reg;
                    min_index_next = scan_idx_reg;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_handle_next = HANDLE_PORT_BITS'(res_handle_reg);
                    m_count_next  = COUNT_PORT_BITS'(count_reg);
                    m_minpos_next = POSITION_PORT_BITS'(min_index_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        issue_reg       <= issue_next;
        pend_idx_reg    <= pend_idx_next;
        scan_min_reg    <= scan_min_next;
        scan_idx_reg    <= scan_idx_next;
        scan_first_reg  <= scan_first_next;
        res_status_reg  <= res_status_next;
        res_handle_reg  <= res_handle_next;
        m_status_reg    <= m_status_next;
        m_handle_reg    <= m_handle_next;
        m_count_reg     <= m_count_next;
        m_minpos_reg    <= m_minpos_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            min_value_reg  <= '1;
            min_index_reg  <= '0;
            capacity_reg   <= CAPACITY_RESET;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            min_value_reg  <= min_value_next;
            min_index_reg  <= min_index_next;
            capacity_reg   <= capacity_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule

[src/ampq_checker.sv]
// Port-level checker for the priority queue and its bind to the top level.
`include "array_min_priority_queue_macros.svh"

module ampq_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_valid,
    input logic                                    s_ready,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input ampq_pkg::status_t                       m_status,
    input logic [ampq_pkg::HANDLE_PORT_BITS-1:0]   m_handle_out,
    input logic [ampq_pkg::COUNT_PORT_BITS-1:0]    m_count,
    input logic [ampq_pkg::POSITION_PORT_BITS-1:0] m_min_position
);

    import ampq_pkg::*;

    `AMPQ_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_handle_out) && $stable(m_count))
    `AMPQ_ASSERT_NEXT(a_one_request_in_flight, s_valid && s_ready, !s_ready)
    `AMPQ_ASSERT_IMM(a_empty_pop_result, m_valid && m_status == STATUS_EMPTY, m_handle_out == '0 && m_count == '0 && m_min_position == '0)
    `AMPQ_ASSERT_IMM(a_full_insert_result, m_valid && m_status == STATUS_FULL, m_handle_out == '0)

endmodule

bind array_min_priority_queue ampq_checker u_ampq_checker (.*);
